// ===== design/i2a_pkg.sv =====
package i2a_pkg;

  localparam int unsigned MAX_PAD_DEF = 63;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned BCD_DIGITS  = 10;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [2:0] {
    FN_SDEC = 3'd0,
    FN_UDEC = 3'd1,
    FN_OCT  = 3'd2,
    FN_HEXL = 3'd3,
    FN_HEXU = 3'd4,
    FN_BIN  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    RDX_DEC = 2'd0,
    RDX_OCT = 2'd1,
    RDX_HEX = 2'd2,
    RDX_BIN = 2'd3
  } radix_t;

  // one finished conversion handed from converter to emitter
  typedef struct packed {
    logic [BCD_W-1:0] digits;
    radix_t           radix;
    logic             upper;
    logic [5:0]       ndig;
    logic [5:0]       npad;
    logic             neg;
    logic             fill;
  } i2a_desc_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else if (upper) begin
      ch = CH_UPPER_A + {4'b0, d - 4'd10};
    end else begin
      ch = CH_LOWER_A + {4'b0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

// ===== design/i2a_conv.sv =====
module i2a_conv #(
  parameter int unsigned MAX_PAD = i2a_pkg::MAX_PAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_func,
  input  logic [31:0]         in_value,
  input  logic [5:0]          in_min_width,
  input  logic                in_zero_fill,
  output logic                desc_valid,
  input  logic                desc_ready,
  output i2a_pkg::i2a_desc_t  desc
);
  import i2a_pkg::*;

  localparam logic [5:0] PAD_LIM = 6'(MAX_PAD);

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_HOLD = 3'b100
  } cv_state_t;

  cv_state_t        state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [VAL_W-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic             seen_r, seen_nxt;
  logic [4:0]       msb_r, msb_nxt;
  radix_t           radix_r, radix_nxt;
  logic             upper_r, upper_nxt;
  logic             neg_r, neg_nxt;
  logic             fill_r, fill_nxt;
  logic [5:0]       pad_r, pad_nxt;
  logic             sbit;
  logic [5:0]       ndig;
  logic [5:0]       width;
  logic [5:0]       npad;
  logic [8:0]       oct_prod;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  assign sbit = sh_r[VAL_W-1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    seen_nxt  = seen_r;
    msb_nxt   = msb_r;
    radix_nxt = radix_r;
    upper_nxt = upper_r;
    neg_nxt   = neg_r;
    fill_nxt  = fill_r;
    pad_nxt   = pad_r;
    unique case (state_r)
      CV_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FN_OCT:  radix_nxt = RDX_OCT;
            FN_HEXL: radix_nxt = RDX_HEX;
            FN_HEXU: radix_nxt = RDX_HEX;
            FN_BIN:  radix_nxt = RDX_BIN;
            default: radix_nxt = RDX_DEC;
          endcase
          upper_nxt = (in_func == FN_HEXU);
          neg_nxt   = (in_func == FN_SDEC) && in_value[VAL_W-1];
          sh_nxt    = neg_nxt ? (~in_value + 32'd1) : in_value;
          fill_nxt  = in_zero_fill;
          pad_nxt   = (in_min_width > PAD_LIM) ? PAD_LIM : in_min_width;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          seen_nxt  = 1'b0;
          msb_nxt   = '0;
          state_nxt = CV_RUN;
        end
      end
      CV_RUN: begin
        // rotate so the magnitude is whole again after 32 steps
        sh_nxt  = {sh_r[VAL_W-2:0], sbit};
        bcd_nxt = {bcd_adj[BCD_W-2:0], sbit};
        if (sbit && !seen_r) begin
          seen_nxt = 1'b1;
          msb_nxt  = ~cnt_r;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = CV_HOLD;
        end
      end
      CV_HOLD: begin
        if (desc_ready) begin
          state_nxt = CV_IDLE;
        end
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  // digit count: top nonzero bcd digit, or msb position per digit size
  always_comb begin
    ndig     = 6'd1;
    oct_prod = 9'(msb_r) * 9'd11;
    unique case (radix_r)
      RDX_DEC: begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
          if (bcd_r[4*i +: 4] != 4'd0) begin
            ndig = 6'(i + 1);
          end
        end
      end
      RDX_OCT: ndig = {2'b0, oct_prod[8:5]} + 6'd1;
      RDX_HEX: ndig = {3'b0, msb_r[4:2]} + 6'd1;
      RDX_BIN: ndig = {1'b0, msb_r} + 6'd1;
      default: ndig = 6'd1;
    endcase
  end

  assign width = ndig + {5'b0, neg_r};
  assign npad  = (pad_r > width) ? (pad_r - width) : 6'd0;

  assign in_ready   = (state_r == CV_IDLE);
  assign desc_valid = (state_r == CV_HOLD);

  always_comb begin
    desc.digits = (radix_r == RDX_DEC) ? bcd_r : {{(BCD_W-VAL_W){1'b0}}, sh_r};
    desc.radix  = radix_r;
    desc.upper  = upper_r;
    desc.ndig   = ndig;
    desc.npad   = npad;
    desc.neg    = neg_r;
    desc.fill   = fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      cnt_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    bcd_r   <= bcd_nxt;
    msb_r   <= msb_nxt;
    radix_r <= radix_nxt;
    upper_r <= upper_nxt;
    neg_r   <= neg_nxt;
    fill_r  <= fill_nxt;
    pad_r   <= pad_nxt;
  end

`ifndef SYNTHESIS
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_RUN) && (cnt_r == 5'd31) |=> (state_r == CV_HOLD))
    else $error("converter did not finish after 32 shifts");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid && !desc_ready |=> desc_valid && $stable(desc))
    else $error("conversion result changed while waiting for emitter");

  a_ndig: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid |-> (desc.ndig != 6'd0) && (desc.ndig <= 6'd32))
    else $error("digit count out of range");
`endif

endmodule

// ===== design/i2a_emit.sv =====
module i2a_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_valid,
  output logic               desc_ready,
  input  i2a_pkg::i2a_desc_t desc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_ascii_char,
  output logic               out_last
);
  import i2a_pkg::*;

  typedef enum logic [3:0] {
    EM_IDLE  = 4'b0001,
    EM_PAD   = 4'b0010,
    EM_SIGN  = 4'b0100,
    EM_DIGIT = 4'b1000
  } em_state_t;

  em_state_t        state_r, state_nxt;
  logic [BCD_W-1:0] dig_r, dig_nxt;
  radix_t           radix_r, radix_nxt;
  logic             upper_r, upper_nxt;
  logic             neg_r, neg_nxt;
  logic             fill_r, fill_nxt;
  logic [5:0]       pad_cnt_r, pad_cnt_nxt;
  logic [4:0]       idx_r, idx_nxt;

  logic [15:0][3:0] nibs;
  logic [15:0][2:0] octs;
  logic [31:0]      bits;
  logic [3:0]       dval;

  assign nibs = {{(64-BCD_W){1'b0}}, dig_r};
  assign octs = {{(48-BCD_W){1'b0}}, dig_r};
  assign bits = dig_r[31:0];

  always_comb begin
    unique case (radix_r)
      RDX_OCT: dval = {1'b0, octs[idx_r[3:0]]};
      RDX_BIN: dval = {3'b0, bits[idx_r]};
      default: dval = nibs[idx_r[3:0]];
    endcase
  end

  always_comb begin
    unique case (state_r)
      EM_PAD:   out_ascii_char = fill_r ? CH_ZERO : CH_SPACE;
      EM_SIGN:  out_ascii_char = CH_MINUS;
      EM_DIGIT: out_ascii_char = digit_char(dval, upper_r);
      default:  out_ascii_char = CH_SPACE;
    endcase
  end

  assign out_valid  = (state_r != EM_IDLE);
  assign out_last   = (state_r == EM_DIGIT) && (idx_r == 5'd0);
  assign desc_ready = (state_r == EM_IDLE);

  always_comb begin
    state_nxt   = state_r;
    dig_nxt     = dig_r;
    radix_nxt   = radix_r;
    upper_nxt   = upper_r;
    neg_nxt     = neg_r;
    fill_nxt    = fill_r;
    pad_cnt_nxt = pad_cnt_r;
    idx_nxt     = idx_r;
    unique case (state_r)
      EM_IDLE: begin
        if (desc_valid) begin
          dig_nxt     = desc.digits;
          radix_nxt   = desc.radix;
          upper_nxt   = desc.upper;
          neg_nxt     = desc.neg;
          fill_nxt    = desc.fill;
          pad_cnt_nxt = desc.npad;
          // a count of 32 wraps to index 31 as wanted
          idx_nxt     = desc.ndig[4:0] - 5'd1;
          priority if (desc.npad != 6'd0) begin
            state_nxt = EM_PAD;
          end else if (desc.neg) begin
            state_nxt = EM_SIGN;
          end else begin
            state_nxt = EM_DIGIT;
          end
        end
      end
      EM_PAD: begin
        if (out_ready) begin
          pad_cnt_nxt = pad_cnt_r - 6'd1;
          if (pad_cnt_r == 6'd1) begin
            state_nxt = neg_r ? EM_SIGN : EM_DIGIT;
          end
        end
      end
      EM_SIGN: begin
        if (out_ready) begin
          state_nxt = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (out_ready) begin
          if (idx_r == 5'd0) begin
            state_nxt = EM_IDLE;
          end else begin
            idx_nxt = idx_r - 5'd1;
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r     <= dig_nxt;
    radix_r   <= radix_nxt;
    upper_r   <= upper_nxt;
    neg_r     <= neg_nxt;
    fill_r    <= fill_nxt;
    pad_cnt_r <= pad_cnt_nxt;
    idx_r     <= idx_nxt;
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid && desc_ready |=> out_valid)
    else $error("emitter took a conversion but shows no word");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("emitter still busy after the final word");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_PAD) |-> (pad_cnt_r != 6'd0))
    else $error("pad phase with nothing left to pad");
`endif

endmodule

// ===== design/integer_to_ascii_padded_top.sv =====
// channel  direction  ports                                      one word is
// in       input      in_valid/in_ready, in_func, in_value,      one conversion
//                     in_min_width, in_zero_fill
// out      output     out_valid/out_ready, out_ascii_char,       one character
//                     out_last
//
// an item's magnitude is shifted bit-serially, all 32 bits, through the
// double-dabble register in the converter, which then holds the result
// until the emitter takes it; the emitter then sends one character per
// cycle while out_ready is high, out_last on the final one
// the converter takes the next item while the emitter drains the last
// rst_n is synchronous, active low; out_ready low holds the current word
module integer_to_ascii_padded_top #(
  parameter int unsigned MAX_PAD = i2a_pkg::MAX_PAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_min_width,
  input  logic        in_zero_fill,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ascii_char,
  output logic        out_last
);
  import i2a_pkg::*;

  i2a_desc_t desc;
  logic      desc_valid;
  logic      desc_ready;

  i2a_conv #(
    .MAX_PAD (MAX_PAD)
  ) u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_value     (in_value),
    .in_min_width (in_min_width),
    .in_zero_fill (in_zero_fill),
    .desc_valid   (desc_valid),
    .desc_ready   (desc_ready),
    .desc         (desc)
  );

  i2a_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc_valid     (desc_valid),
    .desc_ready     (desc_ready),
    .desc           (desc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

endmodule
